[src/hohmann_delta_v_core_assert.svh]
// Assertion macros shared by the Hohmann delta-v core.
`ifndef HOHMANN_DELTA_V_CORE_ASSERT_SVH
`define HOHMANN_DELTA_V_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HDV_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define HDV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define HDV_ASSERT_NOW(label, clk, rst, pre, post)
`define HDV_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[src/hdv_pkg.sv]
// Package with widths, constants and types of the Hohmann delta-v core.
package hdv_pkg;
   localparam int HDV_AW = 25;
   localparam int HDV_OW = 24;
   localparam int HDV_QW = 62;
   localparam int HDV_RW = HDV_QW / 2;
   localparam int HDV_MUW = 35;
   localparam int HDV_SUMW = HDV_AW + 1;
   localparam int HDV_NUMW = HDV_MUW + HDV_AW;
   localparam int HDV_DENW = HDV_AW + HDV_SUMW;
   localparam int HDV_SH_V = 36;
   localparam int HDV_SH_T = 37;
   localparam int HDV_DIV_LAT = HDV_QW + 1;
   localparam int HDV_PIPE = 1 + HDV_DIV_LAT + HDV_RW + 1;
   localparam logic [HDV_MUW-1:0] HDV_MU = 35'd26122678554;
   localparam logic [HDV_AW-1:0] HDV_NEAR_LIMIT = 25'd256;
   localparam logic [HDV_OW-1:0] HDV_NEAR_VALUE = 24'd1049;
   localparam logic [HDV_OW-1:0] HDV_OUT_MAX = {HDV_OW{1'b1}};

   typedef enum logic [1:0] {
      HDV_KIND_CALC,
      HDV_KIND_NEAR,
      HDV_KIND_FULL
   } kind_type;
endpackage

[src/hdv_div.sv]
// Pipelined restoring divider giving floor(x * 2^SH / d) with a saturation flag.
module hdv_div #(
   parameter int XW = 35,
   parameter int SH = 36,
   parameter int DW = 25
) (
   input  logic                       clock,
   input  logic [XW-1:0]              x,
   input  logic [DW-1:0]              d,
   output logic [hdv_pkg::HDV_QW-1:0] q,
   output logic                       sat
);
   import hdv_pkg::*;

   localparam int NW = XW + SH;
   localparam int TW = NW - HDV_QW;
   localparam int CW = (TW > DW) ? TW : DW;

   logic [NW-1:0]     num;
   logic [TW-1:0]     top;
   logic [HDV_QW-1:0] low;

   logic [DW-1:0]     rem_ff  [0:HDV_QW-1];
   logic [DW-1:0]     den_ff  [0:HDV_QW-1];
   logic [HDV_QW-1:0] bits_ff [0:HDV_QW-1];
   logic [HDV_QW-1:0] quo_ff  [0:HDV_QW];
   logic              sat_ff  [0:HDV_QW];

   assign num = {x, {SH{1'b0}}};
   assign top = num[NW-1:HDV_QW];
   assign low = num[HDV_QW-1:0];

   always_ff @(posedge clock) begin
      sat_ff[0]  <= CW'(top) >= CW'(d);
      rem_ff[0]  <= DW'(CW'(top));
      den_ff[0]  <= d;
      bits_ff[0] <= low;
      quo_ff[0]  <= '0;
   end

   for (genvar i = 0; i < HDV_QW; i++) begin : g_stage
      logic [DW:0] part;
      logic        ge;
      assign part = {rem_ff[i], bits_ff[i][HDV_QW-1]};
      assign ge   = part >= {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         quo_ff[i+1] <= {quo_ff[i][HDV_QW-2:0], ge};
         sat_ff[i+1] <= sat_ff[i];
      end

      if (i < HDV_QW - 1) begin : g_pass
         always_ff @(posedge clock) begin
            rem_ff[i+1]  <= ge ? DW'(part - {1'b0, den_ff[i]}) : DW'(part);
            den_ff[i+1]  <= den_ff[i];
            bits_ff[i+1] <= {bits_ff[i][HDV_QW-2:0], 1'b0};
         end
      end
   end

   assign q   = quo_ff[HDV_QW];
   assign sat = sat_ff[HDV_QW];
endmodule

[src/hdv_sqrt.sv]
// Pipelined integer square root, two radicand bits per stage.
module hdv_sqrt (
   input  logic                       clock,
   input  logic [hdv_pkg::HDV_QW-1:0] x,
   output logic [hdv_pkg::HDV_RW-1:0] root
);
   import hdv_pkg::*;

   logic [HDV_RW:0]   rem_ff  [1:HDV_RW-1];
   logic [HDV_QW-1:0] bits_ff [1:HDV_RW-1];
   logic [HDV_RW-1:0] root_ff [1:HDV_RW];

   for (genvar k = 0; k < HDV_RW; k++) begin : g_stage
      logic [HDV_RW:0]   rem_i;
      logic [HDV_RW-1:0] root_i;
      logic [HDV_QW-1:0] bits_i;
      logic [HDV_RW+2:0] cur;
      logic [HDV_RW+2:0] trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_i  = '0;
         assign root_i = '0;
         assign bits_i = x;
      end else begin : g_next
         assign rem_i  = rem_ff[k];
         assign root_i = root_ff[k];
         assign bits_i = bits_ff[k];
      end

      assign cur   = {rem_i, bits_i[HDV_QW-1:HDV_QW-2]};
      assign trial = {1'b0, root_i, 2'b01};
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         root_ff[k+1] <= {root_i[HDV_RW-2:0], ge};
      end

      if (k < HDV_RW - 1) begin : g_pass
         always_ff @(posedge clock) begin
            rem_ff[k+1]  <= ge ? (HDV_RW+1)'(cur - trial) : (HDV_RW+1)'(cur);
            bits_ff[k+1] <= {bits_i[HDV_QW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[HDV_RW];
endmodule

[src/hohmann_delta_v_core.sv]
// Top level of the Hohmann transfer delta-v core.
//
//   Channel   Ports                               Transfer
//   request   start, busy, req_a_from, req_a_to   start high and busy low
//   response  rsp_strobe, rsp_delta_v             one cycle, rsp_strobe high
//
// One transfer is taken in every cycle; busy is always low.
// A result reaches the response ports through 97 register stages: one of
// multipliers, 63 of radix-2 division, 31 of square root and two of
// difference, rounding and saturation. Reset clears the valid bits of the
// pipeline and the response strobe only; the data registers are not reset.
// The receiver cannot stall, so the pipeline never stops.
`include "hohmann_delta_v_core_assert.svh"
module hohmann_delta_v_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [hdv_pkg::HDV_AW-1:0] req_a_from,
   input  logic [hdv_pkg::HDV_AW-1:0] req_a_to,
   output logic                       rsp_strobe,
   output logic [hdv_pkg::HDV_OW-1:0] rsp_delta_v
);
   import hdv_pkg::*;

   logic [HDV_AW-1:0]   a_diff;
   kind_type            kind_in;
   logic [HDV_SUMW-1:0] a_sum;

   logic [HDV_PIPE-1:0] vld_ff;
   kind_type            kind_ff [0:HDV_PIPE-1];

   logic [HDV_AW-1:0]   a_from_ff, a_to_ff;
   logic [HDV_NUMW-1:0] num_t1_ff, num_t2_ff;
   logic [HDV_DENW-1:0] den_t1_ff, den_t2_ff;

   logic [HDV_QW-1:0]   sq_v1, sq_v2, sq_t1, sq_t2;
   logic                sat_v1, sat_v2, sat_t1, sat_t2, sat_any;
   logic [HDV_RW-1:0]   rt_v1, rt_v2, rt_t1, rt_t2;
   kind_type            kind_merge;

   logic [HDV_RW-1:0]   dv1_ff, dv2_ff;
   logic [HDV_RW:0]     dv_sum;
   logic [HDV_RW-1:0]   dv_round;
   logic [HDV_OW-1:0]   delta_in;
   logic [HDV_OW-1:0]   delta_ff;
   logic                strobe_ff;

   assign busy = 1'b0;

   always_comb begin
      a_diff = (req_a_from >= req_a_to) ? req_a_from - req_a_to : req_a_to - req_a_from;
      a_sum  = {1'b0, req_a_from} + {1'b0, req_a_to};
      priority if (a_diff < HDV_NEAR_LIMIT) begin
         kind_in = HDV_KIND_NEAR;
      end else if (req_a_from == '0 || req_a_to == '0) begin
         kind_in = HDV_KIND_FULL;
      end else begin
         kind_in = HDV_KIND_CALC;
      end
   end

   always_ff @(posedge clock) begin
      a_from_ff <= req_a_from;
      a_to_ff   <= req_a_to;
      num_t1_ff <= HDV_NUMW'(HDV_MU) * HDV_NUMW'(req_a_to);
      num_t2_ff <= HDV_NUMW'(HDV_MU) * HDV_NUMW'(req_a_from);
      den_t1_ff <= HDV_DENW'(req_a_from) * HDV_DENW'(a_sum);
      den_t2_ff <= HDV_DENW'(req_a_to) * HDV_DENW'(a_sum);
   end

   hdv_div #(.XW(HDV_MUW), .SH(HDV_SH_V), .DW(HDV_AW)) u_div_v1 (
      .clock(clock), .x(HDV_MU), .d(a_from_ff), .q(sq_v1), .sat(sat_v1));
   hdv_div #(.XW(HDV_MUW), .SH(HDV_SH_V), .DW(HDV_AW)) u_div_v2 (
      .clock(clock), .x(HDV_MU), .d(a_to_ff), .q(sq_v2), .sat(sat_v2));
   hdv_div #(.XW(HDV_NUMW), .SH(HDV_SH_T), .DW(HDV_DENW)) u_div_t1 (
      .clock(clock), .x(num_t1_ff), .d(den_t1_ff), .q(sq_t1), .sat(sat_t1));
   hdv_div #(.XW(HDV_NUMW), .SH(HDV_SH_T), .DW(HDV_DENW)) u_div_t2 (
      .clock(clock), .x(num_t2_ff), .d(den_t2_ff), .q(sq_t2), .sat(sat_t2));

   hdv_sqrt u_sqrt_v1 (.clock(clock), .x(sq_v1), .root(rt_v1));
   hdv_sqrt u_sqrt_v2 (.clock(clock), .x(sq_v2), .root(rt_v2));
   hdv_sqrt u_sqrt_t1 (.clock(clock), .x(sq_t1), .root(rt_t1));
   hdv_sqrt u_sqrt_t2 (.clock(clock), .x(sq_t2), .root(rt_t2));

   assign sat_any    = sat_v1 | sat_v2 | sat_t1 | sat_t2;
   assign kind_merge = (kind_ff[HDV_DIV_LAT] == HDV_KIND_CALC && sat_any) ?
                       HDV_KIND_FULL : kind_ff[HDV_DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[HDV_PIPE-2:0], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      kind_ff[0] <= kind_in;
      for (int i = 1; i < HDV_PIPE; i++) begin
         if (i == HDV_DIV_LAT + 1) begin
            kind_ff[i] <= kind_merge;
         end else begin
            kind_ff[i] <= kind_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dv1_ff <= (rt_t1 >= rt_v1) ? rt_t1 - rt_v1 : rt_v1 - rt_t1;
      dv2_ff <= (rt_t2 >= rt_v2) ? rt_t2 - rt_v2 : rt_v2 - rt_t2;
   end

   always_comb begin
      dv_sum   = {1'b0, dv1_ff} + {1'b0, dv2_ff};
      dv_round = HDV_RW'(((HDV_RW+2)'(dv_sum) + (HDV_RW+2)'(2)) >> 2);
      unique case (kind_ff[HDV_PIPE-1])
         HDV_KIND_NEAR: delta_in = HDV_NEAR_VALUE;
         HDV_KIND_FULL: delta_in = HDV_OUT_MAX;
         default: begin
            if (dv_round > HDV_RW'(HDV_OUT_MAX)) begin
               delta_in = HDV_OUT_MAX;
            end else begin
               delta_in = HDV_OW'(dv_round);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[HDV_PIPE-1];
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_delta_v = delta_ff;

   `HDV_ASSERT_NEXT(a_near_result, clock, reset, vld_ff[HDV_PIPE-1] && kind_ff[HDV_PIPE-1] == HDV_KIND_NEAR, rsp_strobe && rsp_delta_v == HDV_NEAR_VALUE)
   `HDV_ASSERT_NEXT(a_sat_forces_max, clock, reset, vld_ff[HDV_DIV_LAT] && kind_ff[HDV_DIV_LAT] == HDV_KIND_CALC && sat_any, kind_ff[HDV_DIV_LAT+1] == HDV_KIND_FULL)
   `HDV_ASSERT_NOW(a_entry_from_start, clock, reset, vld_ff[0], $past(start))
endmodule

[tb/testbench.sv]
// Self-checking testbench for the Hohmann transfer delta-v core.
`timescale 1ns / 100ps

module testbench;
   import hdv_pkg::*;

   localparam int PIPE_CYCLES = 97;
   localparam logic [24:0] AXIS_MIN = 25'd1630976;
   localparam logic [24:0] AXIS_MAX = 25'h1FFFFFF;
   localparam logic [63:0] SQ_CAP = 64'd1 << 62;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [HDV_AW-1:0] req_a_from;
   logic [HDV_AW-1:0] req_a_to;
   logic rsp_strobe;
   logic [HDV_OW-1:0] rsp_delta_v;

   logic [HDV_OW-1:0] expected_dv[$];
   int mismatch_count = 0;

   hohmann_delta_v_core uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_a_from(req_a_from),
      .req_a_to(req_a_to),
      .rsp_strobe(rsp_strobe),
      .rsp_delta_v(rsp_delta_v)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] scaled_quotient(input logic [63:0] x, input int sh,
                                                   input logic [63:0] d, inout bit ovf);
      logic [63:0] q;
      logic [63:0] r;
      q = x / d;
      r = x % d;
      if (q >= SQ_CAP) begin
         ovf = 1'b1;
         return 64'd0;
      end
      for (int i = 0; i < sh; i++) begin
         if (q >= (SQ_CAP >> 1)) begin
            ovf = 1'b1;
            return 64'd0;
         end
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] b;
      root = 64'd0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x = x - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] end_speed_change(input logic [63:0] a, input logic [63:0] b,
                                                    inout bit ovf);
      logic [63:0] vsq;
      logic [63:0] tsq;
      logic [63:0] v;
      logic [63:0] vt;
      vsq = scaled_quotient(64'(HDV_MU), 36, a, ovf);
      tsq = scaled_quotient(64'(HDV_MU) * b, 37, a * (a + b), ovf);
      if (ovf) return 64'd0;
      v = floor_sqrt(vsq);
      vt = floor_sqrt(tsq);
      return (vt >= v) ? vt - v : v - vt;
   endfunction

   function automatic logic [HDV_OW-1:0] predict_delta_v(input logic [HDV_AW-1:0] a1,
                                                         input logic [HDV_AW-1:0] a2);
      logic [63:0] x1;
      logic [63:0] x2;
      logic [63:0] gap;
      logic [63:0] total;
      bit ovf;
      x1 = 64'(a1);
      x2 = 64'(a2);
      ovf = 1'b0;
      gap = (x1 >= x2) ? x1 - x2 : x2 - x1;
      if (gap < 64'(HDV_NEAR_LIMIT)) return HDV_NEAR_VALUE;
      if (x1 == 0 || x2 == 0) return HDV_OUT_MAX;
      total = end_speed_change(x1, x2, ovf);
      total = total + end_speed_change(x2, x1, ovf);
      if (ovf) return HDV_OUT_MAX;
      total = (total + 2) >> 2;
      if (total > 64'(HDV_OUT_MAX)) return HDV_OUT_MAX;
      return total[HDV_OW-1:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_dv.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: delta_v %0d", rsp_delta_v);
         end else begin
            logic [HDV_OW-1:0] want;
            want = expected_dv.pop_front();
            if (rsp_delta_v !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: delta_v expected %0d, actual %0d", want, rsp_delta_v);
            end
         end
      end
   end

   // The request stays high after the transfer so that bursts run back to back.
   task automatic send_pair(input logic [HDV_AW-1:0] a1, input logic [HDV_AW-1:0] a2);
      @(negedge clock);
      start = 1'b1;
      req_a_from = a1;
      req_a_to = a2;
      do @(posedge clock); while (busy);
      expected_dv.push_back(predict_delta_v(a1, a2));
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained;
      pause(1);
      while (expected_dv.size() != 0) @(posedge clock);
   endtask

   function automatic logic [HDV_AW-1:0] random_axis;
      return 25'($urandom_range(AXIS_MIN, AXIS_MAX));
   endfunction

   task automatic test_near_equal;
      send_pair(AXIS_MIN, AXIS_MIN);
      send_pair(AXIS_MIN, AXIS_MIN + 25'd255);
      send_pair(AXIS_MAX - 25'd255, AXIS_MAX);
      send_pair(AXIS_MAX, AXIS_MAX - 25'd256);
      send_pair(25'd0, 25'd255);
      send_pair(25'd0, 25'd0);
      pause(3);
   endtask

   task automatic test_zero_axis;
      send_pair(25'd0, AXIS_MIN);
      send_pair(AXIS_MAX, 25'd0);
      send_pair(25'd0, 25'd256);
      pause(2);
   endtask

   task automatic test_extremes;
      send_pair(AXIS_MIN, AXIS_MAX);
      send_pair(AXIS_MAX, AXIS_MIN);
      send_pair(25'd1, 25'd300);
      send_pair(25'd256, AXIS_MAX);
      send_pair(25'd1000, 25'd20000);
      send_pair(AXIS_MIN, 25'd1792000);
      send_pair(25'h1555555, 25'h0AAAAAA);
      send_pair(25'h0AAAAAA, 25'h1555555);
      send_pair(AXIS_MIN, AXIS_MIN + 25'd256);
      send_pair(25'd10795008, AXIS_MIN);
      send_pair(25'd100000, AXIS_MAX);
   endtask

   task automatic test_pressure;
      send_pair(random_axis(), random_axis());
      send_pair(random_axis(), random_axis());
      wait_drained();
      send_pair(random_axis(), random_axis());
   endtask

   task automatic test_random;
      int sent;
      int burst;
      int pick;
      logic [HDV_AW-1:0] a1;
      logic [HDV_AW-1:0] a2;
      sent = 0;
      while (sent < 800) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst; i++) begin
            pick = $urandom_range(0, 99);
            a1 = random_axis();
            if (pick < 70) begin
               a2 = random_axis();
            end else if (pick < 80) begin
               a2 = 25'(a1 + $urandom_range(0, 600) - 300);
            end else if (pick < 95) begin
               a1 = 25'($urandom);
               a2 = 25'($urandom);
            end else begin
               a1 = 25'($urandom_range(0, 4096));
               a2 = 25'($urandom);
            end
            if ($urandom_range(0, 1)) send_pair(a1, a2);
            else send_pair(a2, a1);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_a_from = '0;
      req_a_to = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_near_equal();
      test_zero_axis();
      test_extremes();
      test_pressure();
      test_random();
      pause(1);
      for (int i = 0; i < 10 * PIPE_CYCLES && expected_dv.size() != 0; i++)
         @(posedge clock);
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_dv.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
